// ===== src/tpsp_pkg.sv =====
`timescale 1ns / 1ps
package tpsp_pkg;

  // Turn and motor counts
  localparam int STEPS_PER_TURN = 360;
  localparam int MOTOR_COUNT    = 2;

  // Field widths
  localparam int MOTOR_W  = 1;
  localparam int ANGLE_W  = 9;
  localparam int DEG_W    = 9;
  localparam int DUTY_W   = 8;
  localparam int AMP_W    = 8;
  localparam int QSINE_W  = 15;
  localparam int SINE_W   = QSINE_W + 1;
  localparam int PROD_W   = SINE_W + AMP_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 16;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 1;

  typedef enum logic [APB_AW-1:0] {
    REG_AMPLITUDE = 1'b0
  } reg_index_t;

  localparam logic [AMP_W-1:0] AMP_RESET = 8'd255;

  // Step direction codes
  localparam logic DIR_BACKWARD = 1'b1;

  // Phase angles of one motor, as held in the angle memory
  typedef struct packed {
    logic [ANGLE_W-1:0] a;
    logic [ANGLE_W-1:0] b;
    logic [ANGLE_W-1:0] c;
  } angles_t;

  localparam logic [ANGLE_W-1:0] ANGLE_LAST = ANGLE_W'(STEPS_PER_TURN - 1);

  localparam angles_t ANGLES_RESET = '{
    a: '0,
    b: ANGLE_W'(STEPS_PER_TURN / 3),
    c: ANGLE_W'(2 * (STEPS_PER_TURN / 3))
  };

  // Angle to degree: floor(angle * 360 / turn) by a scaled reciprocal,
  // exact for every angle below 512
  localparam int DEG_SHIFT  = 18;
  localparam int DEG_MULT   = (360 * (1 << DEG_SHIFT)) / STEPS_PER_TURN + 1;
  localparam int DEG_PROD_W = 32;

  // Duty bias of 127 in the 16-bit fraction scale
  localparam logic signed [SUM_W-1:0] DUTY_BIAS = SUM_W'(127 * (1 << FRAC_W));
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Quarter-wave sine, one entry a degree, unsigned Q0.15
  localparam logic [QSINE_W-1:0] QUARTER_SINE [91] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
    15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
    15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
    15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
    15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
    15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
    15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
    15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
    15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
    15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
  };

  function automatic logic [DEG_W-1:0] deg_of(input logic [ANGLE_W-1:0] ang);
    logic [DEG_PROD_W-1:0] prod;
    prod = DEG_PROD_W'(ang) * DEG_PROD_W'(DEG_MULT);
    return prod[DEG_SHIFT +: DEG_W];
  endfunction

  // Fold the degree into the first quadrant and apply the sign
  function automatic logic signed [SINE_W-1:0] sine_of(input logic [DEG_W-1:0] deg);
    logic [QSINE_W-1:0] q;
    logic               neg;
    if (deg <= 9'd90) begin
      q   = QUARTER_SINE[7'(deg)];
      neg = 1'b0;
    end else if (deg <= 9'd180) begin
      q   = QUARTER_SINE[7'(9'd180 - deg)];
      neg = 1'b0;
    end else if (deg <= 9'd270) begin
      q   = QUARTER_SINE[7'(deg - 9'd180)];
      neg = 1'b1;
    end else begin
      q   = QUARTER_SINE[7'(9'd360 - deg)];
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Truncate toward zero, clamp to the duty range
  function automatic logic [DUTY_W-1:0] duty_of(input logic [AMP_W-1:0] amp,
                                                input logic signed [SINE_W-1:0] sine);
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-FRAC_W-2:0]  whole;
    prod  = $signed({1'b0, amp}) * sine;
    sum   = DUTY_BIAS + SUM_W'(prod);
    whole = sum[SUM_W-2:FRAC_W];
    if (sum[SUM_W-1]) begin
      return '0;
    end else if (whole > (SUM_W-FRAC_W-1)'(DUTY_MAX)) begin
      return DUTY_MAX;
    end else begin
      return DUTY_W'(whole);
    end
  endfunction

  function automatic logic [ANGLE_W-1:0] advance(input logic [ANGLE_W-1:0] ang,
                                                 input logic backward);
    if (backward) begin
      return (ang == '0) ? ANGLE_LAST : ang - 1'b1;
    end else begin
      return (ang >= ANGLE_LAST) ? '0 : ang + 1'b1;
    end
  endfunction

endpackage

// ===== src/tpsp_ifs.sv =====
`timescale 1ns / 1ps
// Step request channel
interface tpsp_step_if import tpsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MOTOR_W-1:0] motor_select;
  logic               step_direction;

  modport source (output valid, motor_select, step_direction, input ready);
  modport sink   (input valid, motor_select, step_direction, output ready);
endinterface

// Duty result channel
interface tpsp_duty_if import tpsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MOTOR_W-1:0] motor_echo;
  logic [DUTY_W-1:0]  duty_phase_a;
  logic [DUTY_W-1:0]  duty_phase_b;
  logic [DUTY_W-1:0]  duty_phase_c;

  modport source (output valid, motor_echo, duty_phase_a, duty_phase_b, duty_phase_c,
                  input ready);
  modport sink   (input valid, motor_echo, duty_phase_a, duty_phase_b, duty_phase_c,
                  output ready);
endinterface

// ===== src/three_phase_sine_pwm_stepper.sv =====
`timescale 1ns / 1ps
// Three-phase sine PWM stepper for gimbal motors. Each step request names a motor and a
// direction; the block returns the three phase duties from that motor's angles before the
// step and then moves all three angles one step forward or back, wrapping over the turn.
// A request is taken every cycle while the duty output is not held; its result passes the
// read stage, the degree stage and the output register. The rate is set by the
// read-modify-write of the per-motor angle memory, one read and one write a cycle, with the
// just-written entry forwarded to the next request for the same motor. The angle memory
// needs no clearing pass: a valid bit per motor makes an unwritten entry read as 0, 120 and
// 240 degrees. Amplitude sits at address 0 of the APB port and resets to 255.
module three_phase_sine_pwm_stepper import tpsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tpsp_step_if.sink         step_in,
  tpsp_duty_if.source       duty_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [AMP_W-1:0] amplitude;

  logic adv;
  logic accept;
  logic wr_en;

  // Angle memory and its valid bits
  angles_t                mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] ent_valid;

  // Read stage
  logic               s1_valid;
  logic [MOTOR_W-1:0] s1_motor;
  logic               s1_dir;
  logic               s1_ok;
  angles_t            rd_q;
  logic               rd_valid;
  logic               fwd_hit;
  angles_t            fwd_data;
  angles_t            s1_cur;
  angles_t            s1_next;

  // Degree stage
  logic               s2_valid;
  logic [MOTOR_W-1:0] s2_motor;
  logic               s2_ok;
  logic [DEG_W-1:0]   s2_deg_a;
  logic [DEG_W-1:0]   s2_deg_b;
  logic [DEG_W-1:0]   s2_deg_c;

  // Output register
  logic               out_valid;
  logic [MOTOR_W-1:0] out_motor;
  logic [DUTY_W-1:0]  out_duty_a;
  logic [DUTY_W-1:0]  out_duty_b;
  logic [DUTY_W-1:0]  out_duty_c;

  // Advance the whole pipe unless a result is held
  assign adv           = !out_valid || duty_out.ready;
  assign step_in.ready = adv && !rst;
  assign accept        = step_in.valid && step_in.ready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_AMPLITUDE) ? APB_DW'(amplitude) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_AMPLITUDE) begin
      amplitude <= pwdata[AMP_W-1:0];
    end
  end

  // Pick the current angles: forwarded write, stored entry or reset value
  always_comb begin
    if (fwd_hit) begin
      s1_cur = fwd_data;
    end else if (rd_valid) begin
      s1_cur = rd_q;
    end else begin
      s1_cur = ANGLES_RESET;
    end
    s1_next.a = advance(s1_cur.a, s1_dir == DIR_BACKWARD);
    s1_next.b = advance(s1_cur.b, s1_dir == DIR_BACKWARD);
    s1_next.c = advance(s1_cur.c, s1_dir == DIR_BACKWARD);
  end

  assign wr_en = s1_valid && adv && s1_ok;

  // Memory: write back the stepped angles, read for the new request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_motor] <= s1_next;
    end
    if (accept) begin
      rd_q <= mem[step_in.motor_select];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[s1_motor] <= 1'b1;
    end
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_motor <= step_in.motor_select;
      s1_dir   <= step_in.step_direction;
      s1_ok    <= 32'(step_in.motor_select) < 32'(MOTOR_COUNT);
      rd_valid <= ent_valid[step_in.motor_select];
      fwd_hit  <= wr_en && (s1_motor == step_in.motor_select);
      fwd_data <= s1_next;
    end
  end

  // Degree stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_motor <= s1_motor;
      s2_ok    <= s1_ok;
      s2_deg_a <= deg_of(s1_cur.a);
      s2_deg_b <= deg_of(s1_cur.b);
      s2_deg_c <= deg_of(s1_cur.c);
    end
  end

  // Sine lookup, scale and clamp into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_motor  <= s2_motor;
      out_duty_a <= s2_ok ? duty_of(amplitude, sine_of(s2_deg_a)) : '0;
      out_duty_b <= s2_ok ? duty_of(amplitude, sine_of(s2_deg_b)) : '0;
      out_duty_c <= s2_ok ? duty_of(amplitude, sine_of(s2_deg_c)) : '0;
    end
  end

  assign duty_out.valid        = out_valid;
  assign duty_out.motor_echo   = out_motor;
  assign duty_out.duty_phase_a = out_duty_a;
  assign duty_out.duty_phase_b = out_duty_b;
  assign duty_out.duty_phase_c = out_duty_c;

endmodule

// ===== src/tpsp_checker.sv =====
`timescale 1ns / 1ps
module tpsp_checker import tpsp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MOTOR_W-1:0] motor_echo,
  input logic [DUTY_W-1:0]  duty_phase_a,
  input logic [DUTY_W-1:0]  duty_phase_b,
  input logic [DUTY_W-1:0]  duty_phase_c,
  input logic               pready
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_echo) &&
      $stable(duty_phase_a) && $stable(duty_phase_b) && $stable(duty_phase_c))
    else $error("stalled result changed");

  // Drop request ready only while a result is held
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request ready low without a held result");

  // A request passes the read and degree stages into the output while results are being taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready [*2] |=> out_valid)
    else $error("request did not reach the output");

  // Complete every register access at once
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind three_phase_sine_pwm_stepper tpsp_checker u_tpsp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (step_in.valid),
  .in_ready     (step_in.ready),
  .out_valid    (duty_out.valid),
  .out_ready    (duty_out.ready),
  .motor_echo   (duty_out.motor_echo),
  .duty_phase_a (duty_out.duty_phase_a),
  .duty_phase_b (duty_out.duty_phase_b),
  .duty_phase_c (duty_out.duty_phase_c),
  .pready       (pready)
);
